>>> rtl/dtv_pkg.sv
// ----------------------------------------------------------------------------
// dtv_pkg
// Shared types, character codes and helpers of the decimal token validator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtv_pkg;

   // recognizer phases
   typedef enum logic [3:0] {
      PH_LEAD  = 4'd0,
      PH_START = 4'd1,
      PH_INT   = 4'd2,
      PH_FRAC  = 4'd3,
      PH_EXP0  = 4'd4,
      PH_EXPS  = 4'd5,
      PH_EXPD  = 4'd6,
      PH_TRAIL = 4'd7,
      PH_ERR   = 4'd8
   } phase_type;

   // one finished token, as handed from the scanner to the output side
   typedef struct packed {
      logic       ok;
      logic       sep_seen;
      logic [7:0] sep_off;
      logic [7:0] len;
   } result_type;

   // character codes
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // beat widths and queue depth
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 2;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR)
             || (c == CH_FF) || (c == CH_VT);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // body is well formed if it has a mantissa digit and ends in a digit phase
   function automatic logic body_ok(input phase_type ph, input logic mant);
      return mant && ((ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXPD));
   endfunction

endpackage

`default_nettype wire

>>> rtl/dtv_scan.sv
// ----------------------------------------------------------------------------
// dtv_scan
// Front end: steps the token recognizer one byte per beat and, on the last
// byte, produces the token result for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_scan #(
   parameter int MAX_LEN = 255
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               allow_comma,
   input  wire logic               beat,
   input  wire logic [7:0]         ch,
   input  wire logic               last,
   output logic                    push,
   output dtv_pkg::result_type     push_data
);

   localparam int CNT_W = $clog2(MAX_LEN + 2);

   dtv_pkg::phase_type phase_ff, phase_in, phase_step;
   logic               mant_ff, mant_in, mant_step;
   logic               sep_flag_ff, sep_flag_in, sep_flag_step;
   logic [7:0]         sep_place_ff, sep_place_in, sep_place_step;
   logic [7:0]         body_cnt_ff, body_cnt_in, body_cnt_step;
   logic               end_valid_ff, end_valid_in, end_valid_step;
   logic [CNT_W-1:0]   total_cnt_ff, total_cnt_in, total_cnt_step;

   logic ws, digit, sign, exp_mark, sep_char, in_body, head_phase, too_long, ok;

   // byte classes
   always_comb begin
      ws       = dtv_pkg::is_ws(ch);
      digit    = dtv_pkg::is_digit(ch);
      sign     = (ch == dtv_pkg::CH_PLUS) || (ch == dtv_pkg::CH_MINUS);
      exp_mark = (ch == dtv_pkg::CH_LOW_E) || (ch == dtv_pkg::CH_UP_E);
      sep_char = (ch == dtv_pkg::CH_DOT) || ((ch == dtv_pkg::CH_COMMA) && allow_comma);
      // a non-whitespace byte that the grammar still looks at
      in_body  = (phase_ff != dtv_pkg::PH_ERR) && (phase_ff != dtv_pkg::PH_TRAIL) && !ws;
      head_phase = (phase_ff == dtv_pkg::PH_LEAD) || (phase_ff == dtv_pkg::PH_START)
                   || (phase_ff == dtv_pkg::PH_INT);
   end

   // next phase
   always_comb begin
      phase_step = phase_ff;
      if (phase_ff == dtv_pkg::PH_ERR) begin
         phase_step = dtv_pkg::PH_ERR;
      end else if (phase_ff == dtv_pkg::PH_TRAIL) begin
         if (!ws) phase_step = dtv_pkg::PH_ERR;
      end else if (ws) begin
         if (phase_ff != dtv_pkg::PH_LEAD) phase_step = dtv_pkg::PH_TRAIL;
      end else begin
         case (phase_ff)
            dtv_pkg::PH_LEAD, dtv_pkg::PH_START, dtv_pkg::PH_INT: begin
               if ((phase_ff != dtv_pkg::PH_INT) && sign) phase_step = dtv_pkg::PH_INT;
               else if (digit)                          phase_step = dtv_pkg::PH_INT;
               else if (sep_char)                       phase_step = dtv_pkg::PH_FRAC;
               else if (exp_mark && mant_ff)            phase_step = dtv_pkg::PH_EXP0;
               else                                     phase_step = dtv_pkg::PH_ERR;
            end
            dtv_pkg::PH_FRAC: begin
               if (digit)                    phase_step = dtv_pkg::PH_FRAC;
               else if (exp_mark && mant_ff) phase_step = dtv_pkg::PH_EXP0;
               else                          phase_step = dtv_pkg::PH_ERR;
            end
            dtv_pkg::PH_EXP0: begin
               if (sign)       phase_step = dtv_pkg::PH_EXPS;
               else if (digit) phase_step = dtv_pkg::PH_EXPD;
               else            phase_step = dtv_pkg::PH_ERR;
            end
            dtv_pkg::PH_EXPS, dtv_pkg::PH_EXPD: begin
               if (digit) phase_step = dtv_pkg::PH_EXPD;
               else       phase_step = dtv_pkg::PH_ERR;
            end
            default: phase_step = dtv_pkg::PH_ERR;
         endcase
      end

      phase_in = phase_ff;
      if (beat) phase_in = last ? dtv_pkg::PH_LEAD : phase_step;
   end

   // token bookkeeping and result
   always_comb begin
      mant_step = mant_ff | (in_body && digit
                  && (head_phase || (phase_ff == dtv_pkg::PH_FRAC)));
      sep_flag_step  = sep_flag_ff | (in_body && head_phase && sep_char);
      sep_place_step = (in_body && head_phase && sep_char) ? body_cnt_ff : sep_place_ff;
      body_cnt_step  = (in_body && (body_cnt_ff != 8'hFF)) ? body_cnt_ff + 8'd1 : body_cnt_ff;
      // whitespace that closes the body captures its validity
      end_valid_step = (phase_ff != dtv_pkg::PH_ERR) && (phase_ff != dtv_pkg::PH_TRAIL)
                       && (phase_ff != dtv_pkg::PH_LEAD) && ws
                       ? dtv_pkg::body_ok(phase_ff, mant_ff) : end_valid_ff;
      total_cnt_step = (total_cnt_ff <= CNT_W'(MAX_LEN)) ? total_cnt_ff + CNT_W'(1)
                                                          : total_cnt_ff;
      too_long = total_cnt_ff >= CNT_W'(MAX_LEN);

      ok = !too_long && ((phase_step == dtv_pkg::PH_TRAIL) ? end_valid_step
                         : dtv_pkg::body_ok(phase_step, mant_step));

      push               = beat && last;
      push_data.ok       = ok;
      push_data.sep_seen = sep_flag_step;
      push_data.sep_off  = sep_place_step;
      push_data.len      = body_cnt_step;

      // last byte returns the token state to its start
      mant_in      = mant_ff;
      sep_flag_in  = sep_flag_ff;
      sep_place_in = sep_place_ff;
      body_cnt_in  = body_cnt_ff;
      end_valid_in = end_valid_ff;
      total_cnt_in = total_cnt_ff;
      if (beat) begin
         mant_in      = last ? 1'b0 : mant_step;
         sep_flag_in  = last ? 1'b0 : sep_flag_step;
         sep_place_in = last ? 8'd0 : sep_place_step;
         body_cnt_in  = last ? 8'd0 : body_cnt_step;
         end_valid_in = last ? 1'b0 : end_valid_step;
         total_cnt_in = last ? '0 : total_cnt_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= dtv_pkg::PH_LEAD;
         mant_ff      <= 1'b0;
         sep_flag_ff  <= 1'b0;
         sep_place_ff <= 8'd0;
         body_cnt_ff  <= 8'd0;
         end_valid_ff <= 1'b0;
         total_cnt_ff <= '0;
      end else begin
         phase_ff     <= phase_in;
         mant_ff      <= mant_in;
         sep_flag_ff  <= sep_flag_in;
         sep_place_ff <= sep_place_in;
         body_cnt_ff  <= body_cnt_in;
         end_valid_ff <= end_valid_in;
         total_cnt_ff <= total_cnt_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/dtv_queue.sv
// ----------------------------------------------------------------------------
// dtv_queue
// Short register queue of token results between scanner and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire dtv_pkg::result_type  push_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      empty,
   output dtv_pkg::result_type       pop_data
);

   localparam int DEPTH = dtv_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dtv_pkg::result_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      full     = count_ff == CNT_W'(DEPTH);
      empty    = count_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      pop_data = mem_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);

      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (!do_push && do_pop) count_in = count_ff - CNT_W'(1);
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

>>> rtl/dtv_emit.sv
// ----------------------------------------------------------------------------
// dtv_emit
// Back end: formats queued token results and holds the response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_emit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_empty,
   input  wire dtv_pkg::result_type             q_data,
   output logic                                 pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [dtv_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   logic                              valid_ff, valid_in;
   logic [dtv_pkg::RSP_DATA_W-1:0]    data_ff, data_in;

   // a rejected token reports all fields as zero
   always_comb begin
      pop      = !q_empty && (!valid_ff || rsp_tready);
      valid_in = pop || (valid_ff && !rsp_tready);
      data_in  = data_ff;
      if (pop) begin
         data_in = '0;
         if (q_data.ok)
            data_in = {{(dtv_pkg::RSP_DATA_W - 18){1'b0}}, q_data.len,
                       q_data.sep_seen ? q_data.sep_off : 8'd0, q_data.sep_seen, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

>>> rtl/decimal_token_validator_core.sv
// ----------------------------------------------------------------------------
// decimal_token_validator_core
// Streaming recognizer of decimal literals, one token byte per beat.
// ----------------------------------------------------------------------------
// Takes one byte per clock, continuously: the scanner steps its recognizer
// on every accepted byte and stalls only when its two-entry result queue is
// full. One result beat comes out per token, via the queue and the output
// register, which takes a new result every cycle while the sink keeps
// rsp_tready high. allow_comma is written through csr_wr_en/csr_wr_data, by
// the user only while no token is in flight; the block does not enforce it.
// Tokens longer than MAX_LEN bytes, whitespace included, are rejected.
`default_nettype none

module decimal_token_validator_core #(
   parameter int MAX_LEN = 255
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request: tdata[7:0] = ch; tlast = last
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [dtv_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                               req_tlast,
   // response: tdata[0] = accepted, [1] = separator_seen,
   // [9:2] = separator_offset, [17:10] = trimmed_length, [23:18] = 0
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [dtv_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // configuration
   input  wire logic                               csr_wr_en,
   input  wire logic                               csr_wr_data
);

   logic                allow_comma_ff;
   logic                beat, push, pop, q_full, q_empty;
   dtv_pkg::result_type push_data, q_data;

   // allow_comma register
   always_ff @(posedge clock) begin
      if (reset)          allow_comma_ff <= 1'b0;
      else if (csr_wr_en) allow_comma_ff <= csr_wr_data;
   end

   assign req_tready = !q_full;
   assign beat       = req_tvalid && req_tready;

   dtv_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .allow_comma (allow_comma_ff),
      .beat        (beat),
      .ch          (req_tdata),
      .last        (req_tlast),
      .push        (push),
      .push_data   (push_data)
   );

   dtv_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   dtv_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_data     (q_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> rtl/dtv_checker.sv
// ----------------------------------------------------------------------------
// dtv_checker
// Port-level checks of the decimal token validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // stalled response beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // nothing is presented right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // rejected token carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[23:1] == 23'd0)
      else $error("rejected token with nonzero fields");

   // accepted token has a body, a separator offset not above its length, zero padding
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[17:10] != 8'd0 && rsp_tdata[9:2] <= rsp_tdata[17:10]
         && rsp_tdata[23:18] == 6'd0)
      else $error("accepted token with inconsistent length or offset");

endmodule

bind decimal_token_validator_core dtv_checker u_dtv_checker (.*);

`default_nettype wire

>>> tb/sv/tb_decimal_token_validator_core.sv
// ----------------------------------------------------------------------------
// tb_decimal_token_validator_core
// Self-checking bench for the streaming decimal literal recognizer.
// ----------------------------------------------------------------------------
// A queue of token bytes feeds a clocked driver. Every accepted beat steps a
// local scanner that computes the verdict of each finished token. A clocked
// monitor compares each result beat field by field with the oldest verdict.
// Both sides insert random idle cycles. The comma switch is written between
// phases, and only while nothing is in flight.
module tb_decimal_token_validator_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN       = 255;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_BYTES   = 60;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } token_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_tvalid  = 1'b0;
   logic                           req_tready;
   logic [dtv_pkg::REQ_DATA_W-1:0] req_tdata   = '0;
   logic                           req_tlast   = 1'b0;
   logic                           rsp_tvalid;
   logic                           rsp_tready  = 1'b0;
   logic [dtv_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_wr_en   = 1'b0;
   logic                           csr_wr_data = 1'b0;

   // stimulus and expectation stores
   token_beat_type      pending_beats[$];
   dtv_pkg::result_type expected_verdicts[$];
   logic [7:0]          tok_buf[$];

   // local scanner state
   dtv_pkg::phase_type scan_phase  = dtv_pkg::PH_LEAD;
   logic               mant_digit  = 1'b0;
   logic               exp_digit   = 1'b0;
   int                 body_len    = 0;
   int                 sep_pos     = 0;
   logic               sep_found   = 1'b0;
   logic               trail_ok    = 1'b0;
   int                 byte_total  = 0;
   logic               comma_mode  = 1'b0;

   // bookkeeping
   int errors          = 0;
   int cycle_count     = 0;
   int bytes_sent      = 0;
   int tokens_checked  = 0;
   int tokens_accepted = 0;
   int comma_writes    = 0;
   int send_gap        = 0;
   int rsp_stall       = 0;
   bit steady_send     = 1'b0;
   bit steady_recv     = 1'b0;

   decimal_token_validator_core #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // scanner model
   // ---------------------------------------------------------------------
   function automatic logic blank_char(input logic [7:0] c);
      return c == dtv_pkg::CH_SPACE || c == dtv_pkg::CH_TAB || c == dtv_pkg::CH_LF
             || c == dtv_pkg::CH_CR || c == dtv_pkg::CH_FF || c == dtv_pkg::CH_VT;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= dtv_pkg::CH_ZERO && c <= dtv_pkg::CH_NINE;
   endfunction

   function automatic logic body_well_formed();
      return mant_digit && (scan_phase == dtv_pkg::PH_INT || scan_phase == dtv_pkg::PH_FRAC
                            || scan_phase == dtv_pkg::PH_EXPD);
   endfunction

   // one non-blank byte inside the body; body_len is its offset
   task automatic scan_body_char(input logic [7:0] c);
      logic exp_mark;
      logic sign_mark;
      exp_mark  = (c == dtv_pkg::CH_LOW_E) || (c == dtv_pkg::CH_UP_E);
      sign_mark = (c == dtv_pkg::CH_PLUS) || (c == dtv_pkg::CH_MINUS);
      case (scan_phase)
         dtv_pkg::PH_START, dtv_pkg::PH_INT: begin
            if (scan_phase == dtv_pkg::PH_START && sign_mark) begin
               scan_phase = dtv_pkg::PH_INT;
            end else begin
               scan_phase = dtv_pkg::PH_INT;
               if (digit_char(c)) begin
                  mant_digit = 1'b1;
               end else if (c == dtv_pkg::CH_DOT
                            || (c == dtv_pkg::CH_COMMA && comma_mode)) begin
                  sep_found  = 1'b1;
                  sep_pos    = body_len;
                  scan_phase = dtv_pkg::PH_FRAC;
               end else if (exp_mark && mant_digit) begin
                  scan_phase = dtv_pkg::PH_EXP0;
               end else begin
                  scan_phase = dtv_pkg::PH_ERR;
               end
            end
         end
         dtv_pkg::PH_FRAC: begin
            if (digit_char(c)) mant_digit = 1'b1;
            else if (exp_mark && mant_digit) scan_phase = dtv_pkg::PH_EXP0;
            else scan_phase = dtv_pkg::PH_ERR;
         end
         dtv_pkg::PH_EXP0: begin
            if (sign_mark) begin
               scan_phase = dtv_pkg::PH_EXPS;
            end else if (digit_char(c)) begin
               exp_digit  = 1'b1;
               scan_phase = dtv_pkg::PH_EXPD;
            end else begin
               scan_phase = dtv_pkg::PH_ERR;
            end
         end
         dtv_pkg::PH_EXPS, dtv_pkg::PH_EXPD: begin
            if (digit_char(c)) begin
               exp_digit  = 1'b1;
               scan_phase = dtv_pkg::PH_EXPD;
            end else begin
               scan_phase = dtv_pkg::PH_ERR;
            end
         end
         default: scan_phase = dtv_pkg::PH_ERR;
      endcase
   endtask

   // advance on one accepted beat; on the last byte queue the verdict
   task automatic predict_token_byte(input logic [7:0] c, input logic last);
      dtv_pkg::result_type verdict;
      logic                ok;
      if (byte_total <= MAX_LEN) byte_total++;
      if (scan_phase == dtv_pkg::PH_TRAIL) begin
         if (!blank_char(c)) scan_phase = dtv_pkg::PH_ERR;
      end else if (scan_phase != dtv_pkg::PH_ERR) begin
         if (blank_char(c)) begin
            if (scan_phase != dtv_pkg::PH_LEAD) begin
               trail_ok   = body_well_formed();
               scan_phase = dtv_pkg::PH_TRAIL;
            end
         end else begin
            if (scan_phase == dtv_pkg::PH_LEAD) scan_phase = dtv_pkg::PH_START;
            scan_body_char(c);
            if (body_len <= MAX_LEN) body_len++;
         end
      end
      if (last) begin
         ok = (scan_phase == dtv_pkg::PH_TRAIL) ? trail_ok : body_well_formed();
         if (byte_total > MAX_LEN) ok = 1'b0;
         verdict = '0;
         if (ok) begin
            verdict.ok       = 1'b1;
            verdict.sep_seen = sep_found;
            verdict.sep_off  = sep_found ? 8'((sep_pos > 255) ? 255 : sep_pos) : 8'd0;
            verdict.len      = 8'((body_len > 255) ? 255 : body_len);
            tokens_accepted++;
         end
         expected_verdicts.push_back(verdict);
         scan_phase = dtv_pkg::PH_LEAD;
         mant_digit = 1'b0;
         exp_digit  = 1'b0;
         body_len   = 0;
         sep_pos    = 0;
         sep_found  = 1'b0;
         trail_ok   = 1'b0;
         byte_total = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // reporting
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH token %0d %s: got 0x%0h want 0x%0h", tokens_checked, what,
               got, want);
      errors++;
   endtask

   function automatic int draw_idle(input bit steady);
      return steady ? 0 : int'($urandom_range(0, 9));
   endfunction

   // ---------------------------------------------------------------------
   // driver: request side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      token_beat_type b;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_token_byte(req_tdata, req_tlast);
            bytes_sent++;
            if ($urandom_range(0, 39) == 0) steady_send = ~steady_send;
            send_gap = draw_idle(steady_send);
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
               b = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= b.ch;
               req_tlast  <= b.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: result side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      dtv_pkg::result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("unexpected result beat", int'(rsp_tdata), 0);
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_tdata[0] !== want.ok)
                  report_mismatch("accepted", int'(rsp_tdata[0]), int'(want.ok));
               if (rsp_tdata[1] !== want.sep_seen)
                  report_mismatch("separator_seen", int'(rsp_tdata[1]),
                                  int'(want.sep_seen));
               if (rsp_tdata[9:2] !== want.sep_off)
                  report_mismatch("separator_offset", int'(rsp_tdata[9:2]),
                                  int'(want.sep_off));
               if (rsp_tdata[17:10] !== want.len)
                  report_mismatch("trimmed_length", int'(rsp_tdata[17:10]),
                                  int'(want.len));
               if (rsp_tdata[23:18] !== 6'd0)
                  report_mismatch("padding", int'(rsp_tdata[23:18]), 0);
            end
            tokens_checked++;
            if ($urandom_range(0, 19) == 0) steady_recv = ~steady_recv;
            rsp_stall = draw_idle(steady_recv);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
                  expected_verdicts.size());
         $display("FAILURE");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // token building
   // ---------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] c);
      tok_buf.push_back(c);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) tok_buf.push_back(8'(s[i]));
   endtask

   function automatic logic [7:0] any_blank();
      case ($urandom_range(0, 5))
         0: return dtv_pkg::CH_SPACE;
         1: return dtv_pkg::CH_TAB;
         2: return dtv_pkg::CH_LF;
         3: return dtv_pkg::CH_CR;
         4: return dtv_pkg::CH_FF;
         default: return dtv_pkg::CH_VT;
      endcase
   endfunction

   function automatic logic [7:0] any_digit();
      return 8'($urandom_range(dtv_pkg::CH_ZERO, dtv_pkg::CH_NINE));
   endfunction

   // hand the built token to the driver, last mark on its final byte
   task automatic send_token();
      token_beat_type b;
      for (int i = 0; i < tok_buf.size(); i++) begin
         b.ch   = tok_buf[i];
         b.last = (i == tok_buf.size() - 1);
         pending_beats.push_back(b);
      end
      tok_buf.delete();
   endtask

   // mostly well formed literals with random content, some damaged or noise
   task automatic build_random_token();
      int kind;
      int int_n;
      int frac_n;
      int pos;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
      end else begin
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_byte(any_blank());
         if ($urandom_range(0, 2) == 0)
            add_byte($urandom_range(0, 1) ? dtv_pkg::CH_PLUS : dtv_pkg::CH_MINUS);
         int_n  = $urandom_range(0, 4);
         frac_n = $urandom_range(0, 3);
         if (int_n == 0 && frac_n == 0 && $urandom_range(0, 7) != 0) int_n = 1;
         repeat (int_n) add_byte(any_digit());
         if ($urandom_range(0, 1)) begin
            add_byte(($urandom_range(0, 2) == 0) ? dtv_pkg::CH_COMMA : dtv_pkg::CH_DOT);
            repeat (frac_n) add_byte(any_digit());
         end
         if ($urandom_range(0, 2) == 0) begin
            add_byte($urandom_range(0, 1) ? dtv_pkg::CH_LOW_E : dtv_pkg::CH_UP_E);
            if ($urandom_range(0, 1))
               add_byte($urandom_range(0, 1) ? dtv_pkg::CH_PLUS : dtv_pkg::CH_MINUS);
            repeat ($urandom_range(0, 3)) add_byte(any_digit());
         end
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 2)) add_byte(any_blank());
         if (tok_buf.size() == 0) add_byte(any_blank());
         pos = $urandom_range(0, tok_buf.size() - 1);
         // damaged byte, or a blank dropped into the body
         if (kind == 1) tok_buf[pos] = 8'($urandom);
         else if (kind == 2) tok_buf[pos] = any_blank();
      end
   endtask

   // long digit run, optional dot at a given offset
   task automatic build_long_token(input int lead, input int n, input int dot_at);
      repeat (lead) add_byte(any_blank());
      for (int i = 0; i < n; i++) add_byte((i == dot_at) ? dtv_pkg::CH_DOT : any_digit());
   endtask

   // ---------------------------------------------------------------------
   // sequencing
   // ---------------------------------------------------------------------
   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_comma_mode(input logic value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      comma_mode = value;
      comma_writes++;
   endtask

   initial begin
      int queued;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed tokens, comma not allowed
      write_comma_mode(1'b0);
      add_str("9");       send_token();
      add_str("-.5e+3");  send_token();
      add_byte(dtv_pkg::CH_SPACE); add_str("1,2"); add_byte(dtv_pkg::CH_TAB); send_token();
      add_byte(8'h00);    send_token();
      add_byte(8'hFF);    send_token();
      add_byte(dtv_pkg::CH_VT);    add_byte(dtv_pkg::CH_FF); send_token();
      add_str("1 2");     send_token();
      add_str("1e");      send_token();
      wait_idle();

      // comma accepted as separator
      write_comma_mode(1'b1);
      add_byte(dtv_pkg::CH_CR); add_str("3,"); add_byte(dtv_pkg::CH_LF); send_token();
      wait_idle();

      // random phases; the comma switch alternates in the first two, then is drawn at random
      for (int ph = 0; ph < 5; ph++) begin
         write_comma_mode((ph < 2) ? logic'(ph[0]) : logic'($urandom_range(0, 1)));
         queued = 0;
         // longest tokens: right at the limit, and one byte past it
         if (ph == 2) begin
            build_long_token(3, MAX_LEN - 3, $urandom_range(128, MAX_LEN - 5));
            send_token();
         end else if (ph == 3) begin
            build_long_token(0, MAX_LEN + 1, -1);
            send_token();
         end
         while (queued < PHASE_BYTES) begin
            build_random_token();
            queued += tok_buf.size();
            send_token();
         end
         wait_idle();
      end

      $display("Checked %0d tokens (%0d accepted, %0d rejected) over %0d bytes",
               tokens_checked, tokens_accepted, tokens_checked - tokens_accepted,
               bytes_sent);
      $display("Comma switch written %0d times, both settings, with random stalls",
               comma_writes);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", errors);
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/dtv_pkg.sv
rtl/dtv_scan.sv
rtl/dtv_queue.sv
rtl/dtv_emit.sv
rtl/decimal_token_validator_core.sv
rtl/dtv_checker.sv
tb/sv/tb_decimal_token_validator_core.sv
